// ----- rtl/core/tgp_pkg.sv -----
// ----------------------------------------------------------------------------
// Turtle grid plotter package
// Grid size, derived widths, command and heading codes, and the beat types
// of the command and response channels.
// ----------------------------------------------------------------------------
package tgp_pkg;

	localparam int GRID_SIZE = 32;
	localparam int POS_W     = $clog2(GRID_SIZE);
	localparam int DIST_W    = 6;
	localparam int CMP_W     = (POS_W > DIST_W) ? POS_W : DIST_W;
	localparam int QRY_W     = ($clog2(GRID_SIZE + 1) > 5) ? $clog2(GRID_SIZE + 1) : 5;
	localparam int OPOS_W    = (POS_W > 5) ? POS_W : 5;
	localparam int OBITS_W   = (GRID_SIZE > 32) ? GRID_SIZE : 32;

	localparam logic [2:0] ACT_PEN_UP   = 3'd0;
	localparam logic [2:0] ACT_PEN_DOWN = 3'd1;
	localparam logic [2:0] ACT_RIGHT    = 3'd2;
	localparam logic [2:0] ACT_LEFT     = 3'd3;
	localparam logic [2:0] ACT_MOVE     = 3'd4;
	localparam logic [2:0] ACT_READ     = 3'd5;

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_EAST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] distance;
		logic [4:0] query_row;
	} cmd_t;

	typedef struct packed {
		logic        move_ok;
		logic [4:0]  pos_row;
		logic [4:0]  pos_col;
		logic [1:0]  facing;
		logic        pen_is_down;
		logic [31:0] row_bits;
	} rsp_t;

endpackage

// ----- rtl/core/turtle_grid_plotter.sv -----
// A command beat is taken only in idle and passes through the execute and
// finish states; a move south or north with the pen down passes through the
// vertical step state once per cell. The response is registered from the
// finish state, and only then is a new command taken. Rows are drawn by
// read-modify-write. Reset is asynchronous; the bitmap reads as clear at once.
// ----------------------------------------------------------------------------
// Turtle grid plotter
// Keeps position, heading and pen state and draws into a row-wide bitmap
// memory with one read and one write port.
// ----------------------------------------------------------------------------
module turtle_grid_plotter (
	input  logic          clk,
	input  logic          arst_n,
	input  tgp_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	output tgp_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_stall
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_VSTEP = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;

	logic [2:0]                      state_q;
	tgp_pkg::cmd_t                   cmd_q;
	logic [tgp_pkg::POS_W-1:0]       row_q;
	logic [tgp_pkg::POS_W-1:0]       col_q;
	logic [1:0]                      head_q;
	logic                            pen_q;
	logic                            ok_q;
	logic [tgp_pkg::POS_W-1:0]       cnt_q;
	logic                            wr_vld_s1;
	logic [tgp_pkg::POS_W-1:0]       wr_row_s1;
	logic [tgp_pkg::GRID_SIZE-1:0]   wr_mask_s1;
	logic [tgp_pkg::GRID_SIZE-1:0]   mem [tgp_pkg::GRID_SIZE];
	logic [tgp_pkg::GRID_SIZE-1:0]   rd_data_q;
	logic [tgp_pkg::GRID_SIZE-1:0]   row_vld_q;
	tgp_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;

	logic                            cmd_acc;
	logic                            rsp_load;
	logic                            rd_en;
	logic [tgp_pkg::POS_W-1:0]       rd_addr;
	logic [tgp_pkg::GRID_SIZE-1:0]   wr_data;
	logic [tgp_pkg::POS_W-1:0]       edge_pos;
	logic [tgp_pkg::POS_W-1:0]       room;
	logic [tgp_pkg::CMP_W-1:0]       dist_ext;
	logic [tgp_pkg::CMP_W-1:0]       room_ext;
	logic [tgp_pkg::CMP_W-1:0]       steps_ext;
	logic [tgp_pkg::POS_W-1:0]       steps;
	logic                            full_move;
	logic [tgp_pkg::POS_W-1:0]       new_row;
	logic [tgp_pkg::POS_W-1:0]       new_col;
	logic [tgp_pkg::POS_W-1:0]       step_row;
	logic [tgp_pkg::POS_W-1:0]       lo_col;
	logic [tgp_pkg::POS_W-1:0]       hi_col;
	logic [tgp_pkg::GRID_SIZE-1:0]   span_mask;
	logic [tgp_pkg::GRID_SIZE-1:0]   col_mask;
	logic [tgp_pkg::QRY_W-1:0]       qry_ext;
	logic [tgp_pkg::POS_W-1:0]       qidx;
	logic                            q_in_grid;
	logic [tgp_pkg::GRID_SIZE-1:0]   rd_row;
	logic [tgp_pkg::OBITS_W-1:0]     bits_ext;
	logic [tgp_pkg::OPOS_W-1:0]      orow_ext;
	logic [tgp_pkg::OPOS_W-1:0]      ocol_ext;
	logic                            horiz;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign edge_pos = tgp_pkg::POS_W'(tgp_pkg::GRID_SIZE - 1);
	assign horiz    = (head_q == tgp_pkg::DIR_EAST) || (head_q == tgp_pkg::DIR_WEST);

	always_comb begin
		case (head_q)
			tgp_pkg::DIR_NORTH: room = row_q;
			tgp_pkg::DIR_EAST:  room = edge_pos - col_q;
			tgp_pkg::DIR_SOUTH: room = edge_pos - row_q;
			default:            room = col_q;
		endcase
	end

	assign dist_ext  = tgp_pkg::CMP_W'(cmd_q.distance);
	assign room_ext  = tgp_pkg::CMP_W'(room);
	assign steps_ext = (dist_ext < room_ext) ? dist_ext : room_ext;
	assign steps     = steps_ext[tgp_pkg::POS_W-1:0];
	assign full_move = (dist_ext <= room_ext);

	always_comb begin
		new_row = row_q;
		new_col = col_q;
		case (head_q)
			tgp_pkg::DIR_NORTH: new_row = row_q - steps;
			tgp_pkg::DIR_EAST:  new_col = col_q + steps;
			tgp_pkg::DIR_SOUTH: new_row = row_q + steps;
			default:            new_col = col_q - steps;
		endcase
	end

	assign step_row = (head_q == tgp_pkg::DIR_NORTH) ? row_q - 1'b1 : row_q + 1'b1;
	assign lo_col   = (head_q == tgp_pkg::DIR_EAST) ? col_q + 1'b1 : new_col;
	assign hi_col   = (head_q == tgp_pkg::DIR_EAST) ? new_col : col_q - 1'b1;

	always_comb begin
		for (int c = 0; c < tgp_pkg::GRID_SIZE; c++) begin
			span_mask[c] = (tgp_pkg::POS_W'(c) >= lo_col) && (tgp_pkg::POS_W'(c) <= hi_col);
			col_mask[c]  = (tgp_pkg::POS_W'(c) == col_q);
		end
	end

	assign qry_ext   = tgp_pkg::QRY_W'(cmd_q.query_row);
	assign qidx      = qry_ext[tgp_pkg::POS_W-1:0];
	assign q_in_grid = (qry_ext < tgp_pkg::QRY_W'(tgp_pkg::GRID_SIZE));

	assign rd_en   = (state_q == ST_EXEC) || (state_q == ST_VSTEP);
	assign rd_addr = (state_q == ST_VSTEP) ? step_row :
		((cmd_q.action == tgp_pkg::ACT_READ) ? qidx : row_q);

	assign wr_data = (row_vld_q[wr_row_s1] ? rd_data_q : '0) | wr_mask_s1;

	assign rd_row   = ((cmd_q.action == tgp_pkg::ACT_READ) && q_in_grid && row_vld_q[qidx]) ?
		rd_data_q : '0;
	assign bits_ext = tgp_pkg::OBITS_W'(rd_row);
	assign orow_ext = tgp_pkg::OPOS_W'(row_q);
	assign ocol_ext = tgp_pkg::OPOS_W'(col_q);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_vld_s1) begin
			mem[wr_row_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_vld_s1) begin
			row_vld_q[wr_row_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_VSTEP) begin
			wr_row_s1  <= step_row;
			wr_mask_s1 <= col_mask;
		end else if (state_q == ST_EXEC) begin
			wr_row_s1  <= row_q;
			wr_mask_s1 <= (cmd_q.action == tgp_pkg::ACT_MOVE) ? span_mask : col_mask;
		end
		if (rsp_load) begin
			rsp_q.move_ok     <= ok_q;
			rsp_q.pos_row     <= orow_ext[4:0];
			rsp_q.pos_col     <= ocol_ext[4:0];
			rsp_q.facing      <= head_q;
			rsp_q.pen_is_down <= pen_q;
			rsp_q.row_bits    <= bits_ext[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			head_q      <= tgp_pkg::DIR_EAST;
			pen_q       <= 1'b0;
			ok_q        <= 1'b1;
			cnt_q       <= '0;
			wr_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wr_vld_s1 <= 1'b0;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						ok_q    <= 1'b1;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					case (cmd_q.action)
						tgp_pkg::ACT_PEN_UP: begin
							pen_q <= 1'b0;
						end
						tgp_pkg::ACT_PEN_DOWN: begin
							pen_q     <= 1'b1;
							wr_vld_s1 <= 1'b1;
						end
						tgp_pkg::ACT_RIGHT: begin
							head_q <= head_q + 2'd1;
						end
						tgp_pkg::ACT_LEFT: begin
							head_q <= head_q + 2'd3;
						end
						tgp_pkg::ACT_MOVE: begin
							if (room == '0) begin
								ok_q <= 1'b0;
							end else begin
								ok_q <= full_move;
								if (!pen_q || steps == '0) begin
									row_q <= new_row;
									col_q <= new_col;
								end else if (horiz) begin
									col_q     <= new_col;
									wr_vld_s1 <= 1'b1;
								end else begin
									cnt_q   <= steps;
									state_q <= ST_VSTEP;
								end
							end
						end
						default: begin
						end
					endcase
				end
				ST_VSTEP: begin
					row_q     <= step_row;
					cnt_q     <= cnt_q - 1'b1;
					wr_vld_s1 <= 1'b1;
					if (cnt_q == tgp_pkg::POS_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/tgp_checker.sv -----
// ----------------------------------------------------------------------------
// Turtle grid plotter checker
// Watches the command and response ports of the plotter over time.
// ----------------------------------------------------------------------------
module tgp_props (
	input logic          clk,
	input logic          arst_n,
	input tgp_pkg::cmd_t cmd,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input tgp_pkg::rsp_t rsp,
	input logic          rsp_valid,
	input logic          rsp_stall
);

	// A stalled response beat stays valid and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// Commands are handled one at a time.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while another is in progress");

	// Only a row read returns bitmap bits, and a read always succeeds.
	a_bits_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.row_bits != 32'd0) |-> rsp.move_ok)
		else $error("row bits returned with a failed move flag");

	// A response appears only while a command is in progress.
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("response without a command in progress");

endmodule

bind turtle_grid_plotter tgp_props u_tgp_props (.*);

// ----- tb/tgp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Turtle grid plotter checker
// Watches the command and response channels of the plotter. Every accepted
// command beat is run through a local copy of the turtle state and bitmap,
// and the response it must cause is queued. Every accepted response beat is
// compared field by field with the oldest queued response.
// ----------------------------------------------------------------------------
module tgp_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  tgp_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  tgp_pkg::rsp_t rsp,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	output int            outstanding,
	output int            errors
);

	logic [tgp_pkg::POS_W-1:0]     turtle_row;
	logic [tgp_pkg::POS_W-1:0]     turtle_col;
	logic [1:0]                    turtle_heading;
	logic                          turtle_pen;
	logic [tgp_pkg::GRID_SIZE-1:0] drawn [tgp_pkg::GRID_SIZE];
	tgp_pkg::rsp_t                 pending_rsps [$];
	tgp_pkg::rsp_t                 want;

	initial errors = 0;

	function automatic tgp_pkg::rsp_t plot_command(input tgp_pkg::cmd_t c);
		tgp_pkg::rsp_t r;
		int            room;
		int            dist_cells;
		int            steps;
		int            i;
		r          = '0;
		r.move_ok  = 1'b1;
		dist_cells = c.distance;
		case (c.action)
			tgp_pkg::ACT_PEN_UP: begin
				turtle_pen = 1'b0;
			end
			tgp_pkg::ACT_PEN_DOWN: begin
				turtle_pen = 1'b1;
				drawn[turtle_row][turtle_col] = 1'b1;
			end
			tgp_pkg::ACT_RIGHT: begin
				turtle_heading = turtle_heading + 2'd1;
			end
			tgp_pkg::ACT_LEFT: begin
				turtle_heading = turtle_heading - 2'd1;
			end
			tgp_pkg::ACT_MOVE: begin
				case (turtle_heading)
					tgp_pkg::DIR_NORTH: room = turtle_row;
					tgp_pkg::DIR_EAST:  room = tgp_pkg::GRID_SIZE - 1 - turtle_col;
					tgp_pkg::DIR_SOUTH: room = tgp_pkg::GRID_SIZE - 1 - turtle_row;
					default:            room = turtle_col;
				endcase
				if (room == 0) begin
					r.move_ok = 1'b0;
				end else begin
					steps = (dist_cells < room) ? dist_cells : room;
					for (i = 0; i < steps; i++) begin
						case (turtle_heading)
							tgp_pkg::DIR_NORTH: turtle_row = turtle_row - 1'b1;
							tgp_pkg::DIR_EAST:  turtle_col = turtle_col + 1'b1;
							tgp_pkg::DIR_SOUTH: turtle_row = turtle_row + 1'b1;
							default:            turtle_col = turtle_col - 1'b1;
						endcase
						if (turtle_pen) begin
							drawn[turtle_row][turtle_col] = 1'b1;
						end
					end
					r.move_ok = (dist_cells <= room);
				end
			end
			tgp_pkg::ACT_READ: begin
				if (c.query_row < tgp_pkg::GRID_SIZE) begin
					r.row_bits = drawn[c.query_row];
				end
			end
			default: begin
			end
		endcase
		r.pos_row     = turtle_row;
		r.pos_col     = turtle_col;
		r.facing      = turtle_heading;
		r.pen_is_down = turtle_pen;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turtle_row     = '0;
			turtle_col     = '0;
			turtle_heading = tgp_pkg::DIR_EAST;
			turtle_pen     = 1'b0;
			foreach (drawn[r]) drawn[r] = '0;
			pending_rsps.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsps.size() == 0) begin
					$display("%0t: response beat with none expected, actual 0x%0h",
						$time, rsp);
					errors++;
				end else begin
					want = pending_rsps.pop_front();
					check_field("move_ok", want.move_ok, rsp.move_ok);
					check_field("pos_row", want.pos_row, rsp.pos_row);
					check_field("pos_col", want.pos_col, rsp.pos_col);
					check_field("facing", want.facing, rsp.facing);
					check_field("pen_is_down", want.pen_is_down, rsp.pen_is_down);
					check_field("row_bits", want.row_bits, rsp.row_bits);
				end
			end
			if (cmd_valid && !cmd_stall) begin
				pending_rsps.push_back(plot_command(cmd));
			end
			outstanding <= pending_rsps.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Turtle grid plotter testbench
// Drives a directed run of commands over walls, overruns, turns and reads,
// then a long random run with idling on both channels, and reports the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;
	localparam int RANDOM_CMDS    = 1330;
	localparam int WATCHDOG_LIMIT = 2000;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	tgp_pkg::cmd_t cmd       = '0;
	logic          cmd_valid = 1'b0;
	logic          cmd_stall;
	tgp_pkg::rsp_t rsp;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	logic          idling    = 1'b1;
	int            outstanding;
	int            errors;
	int            quiet_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	turtle_grid_plotter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	tgp_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.rsp         (rsp),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.outstanding (outstanding),
		.errors      (errors)
	);

	always @(posedge clk) begin
		rsp_stall <= idling && ($urandom_range(0, 99) < 15);
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic issue_command(input tgp_pkg::cmd_t c);
		if (idling && ($urandom_range(0, 99) < 15)) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic issue(input logic [2:0] act, input logic [5:0] dist_in,
			input logic [4:0] qrow);
		tgp_pkg::cmd_t c;
		c.action    = act;
		c.distance  = dist_in;
		c.query_row = qrow;
		issue_command(c);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic tgp_pkg::cmd_t random_command();
		tgp_pkg::cmd_t c;
		int            pick;
		c.distance  = 6'($urandom_range(0, 63));
		c.query_row = 5'($urandom_range(0, 31));
		pick        = $urandom_range(0, 99);
		if (pick < 40) begin
			c.action   = tgp_pkg::ACT_MOVE;
			c.distance = (pick < 32) ? 6'($urandom_range(0, 12)) : 6'($urandom_range(0, 63));
		end else if (pick < 52) begin
			c.action = tgp_pkg::ACT_RIGHT;
		end else if (pick < 64) begin
			c.action = tgp_pkg::ACT_LEFT;
		end else if (pick < 72) begin
			c.action = tgp_pkg::ACT_PEN_DOWN;
		end else if (pick < 80) begin
			c.action = tgp_pkg::ACT_PEN_UP;
		end else if (pick < 96) begin
			c.action = tgp_pkg::ACT_READ;
		end else begin
			c.action = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
		end
		return c;
	endfunction

	initial begin
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The turtle starts in the north-west corner facing east.
		issue(tgp_pkg::ACT_READ, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_MOVE, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_PEN_DOWN, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_MOVE, 6'd63, 5'd0);
		issue(tgp_pkg::ACT_MOVE, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_RIGHT, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_MOVE, 6'd31, 5'd0);
		issue(tgp_pkg::ACT_READ, 6'd0, 5'd31);
		issue(tgp_pkg::ACT_RIGHT, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_MOVE, 6'd40, 5'd0);
		issue(tgp_pkg::ACT_RIGHT, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_MOVE, 6'd63, 5'd0);
		issue(tgp_pkg::ACT_LEFT, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_MOVE, 6'd1, 5'd0);
		issue(tgp_pkg::ACT_LEFT, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_LEFT, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_LEFT, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_PEN_UP, 6'd63, 5'd31);
		issue(ACT_SPARE_A, 6'd63, 5'd31);
		issue(ACT_SPARE_B, 6'd21, 5'd10);
		issue(tgp_pkg::ACT_READ, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_READ, 6'd0, 5'd15);
		issue(tgp_pkg::ACT_RIGHT, 6'd0, 5'd0);
		issue(tgp_pkg::ACT_MOVE, 6'd10, 5'd0);
		wait_drained();

		for (n = 0; n < RANDOM_CMDS; n++) begin
			idling <= !(n >= 400 && n < 650);
			if (n == 900) begin
				wait_drained();
			end
			issue_command(random_command());
		end
		cmd_valid <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);

		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ----- turtle_grid_plotter.f -----
rtl/core/tgp_pkg.sv
rtl/core/turtle_grid_plotter.sv
rtl/core/tgp_checker.sv
tb/tgp_checker.sv
tb/tb.sv
